// File: hdl/esic_pkg.sv
package esic_pkg;

  localparam int unsigned DimMax = 4096;
  localparam int unsigned AddrW  = $clog2(DimMax);
  localparam int unsigned PtrW   = $clog2(DimMax + 1);

  localparam int unsigned FuncW   = 3;
  localparam int unsigned IdxW    = 12;
  localparam int unsigned CntW    = 13;
  localparam int unsigned RankW   = 12;
  localparam int unsigned StatusW = 2;

  localparam logic [FuncW-1:0] FuncStart   = 3'd0;
  localparam logic [FuncW-1:0] FuncMark    = 3'd1;
  localparam logic [FuncW-1:0] FuncBuild   = 3'd2;
  localparam logic [FuncW-1:0] FuncRelabel = 3'd3;
  localparam logic [FuncW-1:0] FuncLookup  = 3'd4;

  localparam logic [StatusW-1:0] StatusOk        = 2'd0;
  localparam logic [StatusW-1:0] StatusRange     = 2'd1;
  localparam logic [StatusW-1:0] StatusNotMapped = 2'd2;

  localparam logic [CntW-1:0] DimSizeReset = 13'd4096;

endpackage

// File: hdl/esic_req_if.sv
interface esic_req_if;
  logic                          valid;
  logic                          ready;
  logic [esic_pkg::FuncW-1:0]    func;
  logic [esic_pkg::IdxW-1:0]     index;

  modport source (output valid, func, index, input ready);
  modport sink   (input valid, func, index, output ready);
endinterface

// File: hdl/esic_rsp_if.sv
interface esic_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [esic_pkg::CntW-1:0]     result_value;
  logic [esic_pkg::CntW-1:0]     removed_count;
  logic                          remap_needed;
  logic [esic_pkg::StatusW-1:0]  status;

  modport source (output valid, result_value, removed_count, remap_needed, status,
                  input ready);
  modport sink   (input valid, result_value, removed_count, remap_needed, status,
                  output ready);
endinterface

// File: hdl/esic_ram.sv
module esic_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/empty_slice_index_compactor.sv
// Index compactor for one tensor mode. Send start, one mark word per nonzero index, one
// build word, then relabel and lookup words; each input word yields exactly one result
// word. Mark, relabel, lookup and unused codes read the mark/rank memory and the map
// memory, then give the result. Build scans the mark/rank memory one entry per cycle
// through its single read port. Start clears all 4096 entries of that memory one entry per
// cycle. After reset the same clearing pass runs before the first input word is taken;
// dim_size writes are taken at any time. A finished result sits in an output register, so
// the next word is accepted while it waits.
module empty_slice_index_compactor (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [esic_pkg::CntW-1:0]  cfg_wdata_i,
  esic_req_if.sink                   req_i,
  esic_rsp_if.source                 rsp_o
);

  localparam int unsigned MarkW = esic_pkg::RankW + 1;

  typedef enum logic [2:0] {
    StIdle,
    StExec,
    StScan,
    StBuildDone,
    StClear,
    StStartDone
  } state_e;

  state_e                          state_q, state_d;
  logic [esic_pkg::FuncW-1:0]      func_q, func_d;
  logic [esic_pkg::IdxW-1:0]       idx_q, idx_d;
  logic [esic_pkg::CntW-1:0]       dim_size_q, dim_size_d;
  logic [esic_pkg::CntW-1:0]       unique_q, unique_d;
  logic                            built_q, built_d;
  logic [esic_pkg::PtrW-1:0]       ptr_q, ptr_d;
  logic                            scan_vld_q, scan_vld_d;
  logic [esic_pkg::AddrW-1:0]      scan_addr_q, scan_addr_d;
  logic [esic_pkg::CntW-1:0]       next_q, next_d;
  logic                            resp_pend_q, resp_pend_d;
  logic                            out_vld_q, out_vld_d;
  logic [esic_pkg::CntW-1:0]       out_value_q, out_value_d;
  logic [esic_pkg::CntW-1:0]       out_removed_q, out_removed_d;
  logic                            out_remap_q, out_remap_d;
  logic [esic_pkg::StatusW-1:0]    out_status_q, out_status_d;

  logic                            mark_we, mark_re;
  logic [esic_pkg::AddrW-1:0]      mark_waddr, mark_raddr;
  logic [MarkW-1:0]                mark_wdata, mark_rdata;
  logic                            map_we, map_re;
  logic [esic_pkg::AddrW-1:0]      map_waddr, map_raddr;
  logic [esic_pkg::IdxW-1:0]       map_wdata, map_rdata;

  logic [esic_pkg::CntW-1:0]       size;
  logic                            slot_free;
  logic                            idx_in_range;
  logic                            seen;
  logic [esic_pkg::RankW-1:0]      rank;
  logic [esic_pkg::CntW-1:0]       removed;

  esic_ram #(
    .Width (MarkW),
    .Depth (esic_pkg::DimMax)
  ) u_mark_ram (
    .clk_i   (clk_i),
    .we_i    (mark_we),
    .waddr_i (mark_waddr),
    .wdata_i (mark_wdata),
    .re_i    (mark_re),
    .raddr_i (mark_raddr),
    .rdata_o (mark_rdata)
  );

  esic_ram #(
    .Width (esic_pkg::IdxW),
    .Depth (esic_pkg::DimMax)
  ) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (map_we),
    .waddr_i (map_waddr),
    .wdata_i (map_wdata),
    .re_i    (map_re),
    .raddr_i (map_raddr),
    .rdata_o (map_rdata)
  );

  assign size = (32'(dim_size_q) > esic_pkg::DimMax) ? esic_pkg::CntW'(esic_pkg::DimMax)
                                                     : dim_size_q;
  assign slot_free    = !out_vld_q || rsp_o.ready;
  assign idx_in_range = esic_pkg::CntW'(idx_q) < size;
  assign seen         = mark_rdata[esic_pkg::RankW];
  assign rank         = mark_rdata[esic_pkg::RankW-1:0];
  assign removed      = size - next_q;

  assign req_i.ready         = (state_q == StIdle);
  assign rsp_o.valid         = out_vld_q;
  assign rsp_o.result_value  = out_value_q;
  assign rsp_o.removed_count = out_removed_q;
  assign rsp_o.remap_needed  = out_remap_q;
  assign rsp_o.status        = out_status_q;

  always_comb begin
    state_d       = state_q;
    func_d        = func_q;
    idx_d         = idx_q;
    dim_size_d    = dim_size_q;
    unique_d      = unique_q;
    built_d       = built_q;
    ptr_d         = ptr_q;
    scan_vld_d    = 1'b0;
    scan_addr_d   = scan_addr_q;
    next_d        = next_q;
    resp_pend_d   = resp_pend_q;
    out_vld_d     = out_vld_q && !rsp_o.ready;
    out_value_d   = out_value_q;
    out_removed_d = out_removed_q;
    out_remap_d   = out_remap_q;
    out_status_d  = out_status_q;

    mark_we    = 1'b0;
    mark_waddr = esic_pkg::AddrW'(idx_q);
    mark_wdata = {1'b1, rank};
    mark_re    = 1'b0;
    mark_raddr = esic_pkg::AddrW'(req_i.index);
    map_we     = 1'b0;
    map_waddr  = esic_pkg::AddrW'(rank);
    map_wdata  = idx_q;
    map_re     = 1'b0;
    map_raddr  = esic_pkg::AddrW'(req_i.index);

    case (state_q)
      StIdle: begin
        if (req_i.valid) begin
          func_d  = req_i.func;
          idx_d   = req_i.index;
          mark_re = 1'b1;
          map_re  = 1'b1;
          case (req_i.func)
            esic_pkg::FuncStart: begin
              state_d     = StClear;
              ptr_d       = '0;
              resp_pend_d = 1'b1;
              unique_d    = '0;
              built_d     = 1'b0;
            end
            esic_pkg::FuncBuild: begin
              state_d = StScan;
              ptr_d   = '0;
              next_d  = '0;
            end
            default: begin
              state_d = StExec;
            end
          endcase
        end
      end

      StExec: begin
        if (slot_free) begin
          state_d       = StIdle;
          out_vld_d     = 1'b1;
          out_value_d   = '0;
          out_removed_d = '0;
          out_remap_d   = 1'b0;
          out_status_d  = esic_pkg::StatusOk;
          case (func_q)
            esic_pkg::FuncMark: begin
              if (!idx_in_range) begin
                out_status_d = esic_pkg::StatusRange;
              end else begin
                built_d = 1'b0;
                if (!seen) begin
                  mark_we  = 1'b1;
                  unique_d = unique_q + 1'b1;
                end
                out_value_d = unique_d;
              end
            end
            esic_pkg::FuncRelabel: begin
              if (!idx_in_range) begin
                out_status_d = esic_pkg::StatusRange;
              end else if (!built_q || !seen) begin
                out_status_d = esic_pkg::StatusNotMapped;
              end else begin
                map_we      = (32'(rank) < esic_pkg::DimMax);
                out_value_d = esic_pkg::CntW'(rank);
              end
            end
            esic_pkg::FuncLookup: begin
              if (!idx_in_range) begin
                out_status_d = esic_pkg::StatusRange;
              end else if (!built_q || (esic_pkg::CntW'(idx_q) >= unique_q)) begin
                out_status_d = esic_pkg::StatusNotMapped;
              end else begin
                out_value_d = esic_pkg::CntW'(map_rdata);
              end
            end
            default: begin
            end
          endcase
        end
      end

      StScan: begin
        if (esic_pkg::CntW'(ptr_q) < size) begin
          mark_re     = 1'b1;
          mark_raddr  = ptr_q[esic_pkg::AddrW-1:0];
          scan_vld_d  = 1'b1;
          scan_addr_d = ptr_q[esic_pkg::AddrW-1:0];
          ptr_d       = ptr_q + 1'b1;
        end else if (!scan_vld_q) begin
          state_d = StBuildDone;
        end
        if (scan_vld_q && seen) begin
          mark_we    = 1'b1;
          mark_waddr = scan_addr_q;
          mark_wdata = {1'b1, next_q[esic_pkg::RankW-1:0]};
          next_d     = next_q + 1'b1;
        end
      end

      StBuildDone: begin
        if (slot_free) begin
          state_d       = StIdle;
          unique_d      = next_q;
          built_d       = 1'b1;
          out_vld_d     = 1'b1;
          out_value_d   = next_q;
          out_removed_d = removed;
          out_remap_d   = |removed;
          out_status_d  = esic_pkg::StatusOk;
        end
      end

      StClear: begin
        mark_we    = 1'b1;
        mark_waddr = ptr_q[esic_pkg::AddrW-1:0];
        mark_wdata = '0;
        ptr_d      = ptr_q + 1'b1;
        if (ptr_q == esic_pkg::PtrW'(esic_pkg::DimMax - 1)) begin
          state_d = resp_pend_q ? StStartDone : StIdle;
        end
      end

      StStartDone: begin
        if (slot_free) begin
          state_d       = StIdle;
          resp_pend_d   = 1'b0;
          out_vld_d     = 1'b1;
          out_value_d   = '0;
          out_removed_d = '0;
          out_remap_d   = 1'b0;
          out_status_d  = esic_pkg::StatusOk;
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase

    if (cfg_we_i) begin
      dim_size_d = cfg_wdata_i;
      built_d    = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      dim_size_q  <= esic_pkg::DimSizeReset;
      unique_q    <= '0;
      built_q     <= 1'b0;
      ptr_q       <= '0;
      scan_vld_q  <= 1'b0;
      next_q      <= '0;
      resp_pend_q <= 1'b0;
      out_vld_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      dim_size_q  <= dim_size_d;
      unique_q    <= unique_d;
      built_q     <= built_d;
      ptr_q       <= ptr_d;
      scan_vld_q  <= scan_vld_d;
      next_q      <= next_d;
      resp_pend_q <= resp_pend_d;
      out_vld_q   <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q        <= func_d;
    idx_q         <= idx_d;
    scan_addr_q   <= scan_addr_d;
    out_value_q   <= out_value_d;
    out_removed_q <= out_removed_d;
    out_remap_q   <= out_remap_d;
    out_status_q  <= out_status_d;
  end

endmodule
